/* sv/erp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package erp_pkg;

    // Fixed field widths
    localparam int COORD_WIDTH     = 32;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    // CORDIC datapath: Q3.30 vector, angle in units of 2^-32 turn
    localparam int CORDIC_STEPS  = 30;
    localparam int CORDIC_STEP_W = 5;
    localparam int CORDIC_XY_W   = 34;
    localparam int CORDIC_Z_W    = 33;
    localparam logic signed [CORDIC_XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_YAW   = 2'd0,
        CFG_PITCH = 2'd1,
        CFG_ROLL  = 2'd2,
        CFG_MODE  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
        logic signed [COORD_WIDTH-1:0] z_coord;
        logic                          last_point;
    } point_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_rotated;
        logic signed [COORD_WIDTH-1:0] y_rotated;
        logic signed [COORD_WIDTH-1:0] z_rotated;
        logic                          last_rotated;
    } point_out_t;

    // Arctangent of 2^-step in units of 2^-32 turn
    function automatic logic signed [CORDIC_Z_W-1:0] atan_turn(
        input logic [CORDIC_STEP_W-1:0] step
    );
        logic signed [CORDIC_Z_W-1:0] val;
        case (step)
            5'd0:    val = 33'sd536870912;
            5'd1:    val = 33'sd316933406;
            5'd2:    val = 33'sd167458907;
            5'd3:    val = 33'sd85004756;
            5'd4:    val = 33'sd42667331;
            5'd5:    val = 33'sd21354465;
            5'd6:    val = 33'sd10679838;
            5'd7:    val = 33'sd5340245;
            5'd8:    val = 33'sd2670163;
            5'd9:    val = 33'sd1335087;
            5'd10:   val = 33'sd667544;
            5'd11:   val = 33'sd333772;
            5'd12:   val = 33'sd166886;
            5'd13:   val = 33'sd83443;
            5'd14:   val = 33'sd41722;
            5'd15:   val = 33'sd20861;
            5'd16:   val = 33'sd10430;
            5'd17:   val = 33'sd5215;
            5'd18:   val = 33'sd2608;
            5'd19:   val = 33'sd1304;
            5'd20:   val = 33'sd652;
            5'd21:   val = 33'sd326;
            5'd22:   val = 33'sd163;
            5'd23:   val = 33'sd81;
            5'd24:   val = 33'sd41;
            5'd25:   val = 33'sd20;
            5'd26:   val = 33'sd10;
            5'd27:   val = 33'sd5;
            5'd28:   val = 33'sd3;
            5'd29:   val = 33'sd1;
            default: val = 33'sd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

/* sv/euler_rotation_of_points.sv */
// A point passes through three registers (input, products, rounded output); one beat per cycle
// is sustained while out_ready is high and no rebuild is pending. After a configuration write
// the rotation matrix is rebuilt by three CORDIC runs on one shared unit, then 54
// multiply-accumulate steps; input beats are held off during the rebuild.
// Reset: angles and mode clear to zero, the matrix to identity, the pipeline empties.
`timescale 1ns / 1ps
`default_nettype none

module euler_rotation_of_points #(
    parameter int COEF_FRAC_BITS = 16,
    parameter int ANGLE_WIDTH    = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [erp_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [erp_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  erp_pkg::point_in_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output erp_pkg::point_out_t                   out_data
);

    localparam int EXT_W = erp_pkg::CFG_DATA_WIDTH + 32;

    logic [erp_pkg::CFG_DATA_WIDTH-1:0] yaw_reg, pitch_reg, roll_reg;
    logic                               mode_reg;
    logic                               rebuild_reg;
    logic                               build_busy, hold;
    logic [EXT_W-1:0]                   yaw_ext, pitch_ext, roll_ext;
    logic [8:0][COEF_FRAC_BITS+1:0]     matrix;

    // Register writes; every write triggers a rebuild in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg     <= '0;
            pitch_reg   <= '0;
            roll_reg    <= '0;
            mode_reg    <= 1'b0;
            rebuild_reg <= 1'b0;
        end
        else
        begin
            rebuild_reg <= cfg_we;
            if (cfg_we)
            begin
                unique case (erp_pkg::cfg_index_t'(cfg_index))
                    erp_pkg::CFG_YAW:   yaw_reg   <= cfg_data;
                    erp_pkg::CFG_PITCH: pitch_reg <= cfg_data;
                    erp_pkg::CFG_ROLL:  roll_reg  <= cfg_data;
                    erp_pkg::CFG_MODE:  mode_reg  <= cfg_data[0];
                endcase
            end
        end
    end

    // Angles wrap modulo a turn
    assign yaw_ext   = EXT_W'(yaw_reg);
    assign pitch_ext = EXT_W'(pitch_reg);
    assign roll_ext  = EXT_W'(roll_reg);

    erp_matrix_build #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS),
        .ANGLE_WIDTH   (ANGLE_WIDTH)
    ) u_build (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rebuild_reg),
        .yaw       (yaw_ext[ANGLE_WIDTH-1:0]),
        .pitch     (pitch_ext[ANGLE_WIDTH-1:0]),
        .roll      (roll_ext[ANGLE_WIDTH-1:0]),
        .derivative(mode_reg),
        .busy      (build_busy),
        .matrix    (matrix)
    );

    // Hold off points while the matrix may change
    assign hold = cfg_we || rebuild_reg || build_busy;

    erp_point_pipe #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (hold),
        .matrix   (matrix),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    a_no_beat_during_build : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (!build_busy && !rebuild_reg))
        else $error("point beat taken while matrix rebuild pending");

    a_matrix_steady : assert property (@(posedge clk) disable iff (!rst_n)
        (!build_busy && !rebuild_reg) |=> $stable(matrix))
        else $error("matrix changed outside a rebuild");

    a_build_after_write : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(build_busy) |-> $past(rebuild_reg))
        else $error("rebuild started without a register write");

endmodule

`default_nettype wire

/* sv/erp_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none

module erp_cordic #(
    parameter int COEF_FRAC_BITS = 16,
    parameter int ANGLE_WIDTH    = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ANGLE_WIDTH-1:0]           angle,
    output logic                             done,
    output logic signed [COEF_FRAC_BITS+1:0] sin_val,
    output logic signed [COEF_FRAC_BITS+1:0] cos_val
);

    localparam int COEF_W      = COEF_FRAC_BITS + 2;
    localparam int XY_W        = erp_pkg::CORDIC_XY_W;
    localparam int Z_W         = erp_pkg::CORDIC_Z_W;
    localparam int STEP_W      = erp_pkg::CORDIC_STEP_W;
    localparam int ROUND_SHIFT = 30 - COEF_FRAC_BITS;
    localparam logic signed [XY_W-1:0] HALF = XY_W'(1) << (ROUND_SHIFT - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(erp_pkg::CORDIC_STEPS - 1);

    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [1:0]             quad_reg, quad_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [ANGLE_WIDTH-3:0] frac;
    logic signed [XY_W-1:0] dx, dy;
    logic signed [XY_W-1:0] cos_full, sin_full;
    logic signed [COEF_W-1:0] c_q, s_q;

    assign frac = angle[ANGLE_WIDTH-3:0];

    // Load the start vector or run one micro-rotation
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        quad_next = quad_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dx        = y_reg >>> step_reg;
        dy        = x_reg >>> step_reg;
        if (start)
        begin
            x_next    = erp_pkg::CORDIC_GAIN;
            y_next    = '0;
            z_next    = $signed(Z_W'(frac) << (32 - ANGLE_WIDTH));
            quad_next = angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - erp_pkg::atan_turn(step_reg);
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + erp_pkg::atan_turn(step_reg);
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
    end

    // Round to the coefficient format and unfold the quadrant
    assign cos_full = (x_reg + HALF) >>> ROUND_SHIFT;
    assign sin_full = (y_reg + HALF) >>> ROUND_SHIFT;
    assign c_q      = cos_full[COEF_W-1:0];
    assign s_q      = sin_full[COEF_W-1:0];

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                sin_val = s_q;
                cos_val = c_q;
            end
            2'd1:
            begin
                sin_val = c_q;
                cos_val = -s_q;
            end
            2'd2:
            begin
                sin_val = -s_q;
                cos_val = -c_q;
            end
            default:
            begin
                sin_val = -c_q;
                cos_val = s_q;
            end
        endcase
    end

    assign done = done_reg;

endmodule

`default_nettype wire

/* sv/erp_matrix_build.sv */
`timescale 1ns / 1ps
`default_nettype none

module erp_matrix_build #(
    parameter int COEF_FRAC_BITS = 16,
    parameter int ANGLE_WIDTH    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [ANGLE_WIDTH-1:0]              yaw,
    input  logic [ANGLE_WIDTH-1:0]              pitch,
    input  logic [ANGLE_WIDTH-1:0]              roll,
    input  logic                                derivative,
    output logic                                busy,
    output logic [8:0][COEF_FRAC_BITS+1:0]      matrix
);

    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int ACC_W  = 2 * COEF_W + 2;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef enum logic [1:0] {ST_IDLE, ST_TRIG, ST_MUL} state_t;

    localparam coef_t ONE    = coef_t'(COEF_W'(1) << COEF_FRAC_BITS);
    localparam coef_t LIM_HI = {1'b0, {(COEF_W-1){1'b1}}};
    localparam coef_t LIM_LO = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [1:0] TRIG_YAW  = 2'd0;
    localparam logic [1:0] TRIG_ROLL = 2'd2;
    localparam logic [1:0] IDX_LAST  = 2'd2;

    state_t      state_reg;
    logic [1:0]  trig_reg;
    logic        pass_reg;
    logic [1:0]  row_reg, col_reg, k_reg;
    coef_t       sin_reg [3];
    coef_t       cos_reg [3];
    coef_t       t_reg   [9];
    coef_t       mat_reg [9];
    logic signed [ACC_W-1:0] acc_reg;

    logic                    trig_start, trig_done;
    logic [ANGLE_WIDTH-1:0]  trig_angle;
    coef_t                   trig_sin, trig_cos;
    coef_t                   rz [9];
    coef_t                   ry [9];
    coef_t                   rx [9];
    logic [3:0]              a_idx, b_idx, o_idx;
    coef_t                   a_val, b_val, res;
    logic signed [2*COEF_W-1:0] prod;
    logic signed [ACC_W-1:0] sum, rounded;

    // Shared sine/cosine unit, one angle after another
    assign trig_start = start
                     || (state_reg == ST_TRIG && trig_done && trig_reg != TRIG_ROLL);
    assign trig_angle = start ? yaw : ((trig_reg == TRIG_YAW) ? pitch : roll);

    erp_cordic #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS),
        .ANGLE_WIDTH   (ANGLE_WIDTH)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (trig_start),
        .angle  (trig_angle),
        .done   (trig_done),
        .sin_val(trig_sin),
        .cos_val(trig_cos)
    );

    // Elementary rotations from the held sines and cosines
    always_comb
    begin
        rz[0] = cos_reg[0];  rz[1] = -sin_reg[0]; rz[2] = '0;
        rz[3] = sin_reg[0];  rz[4] = cos_reg[0];  rz[5] = '0;
        rz[6] = '0;          rz[7] = '0;          rz[8] = ONE;
        ry[0] = cos_reg[1];  ry[1] = '0;          ry[2] = sin_reg[1];
        ry[3] = '0;          ry[4] = ONE;         ry[5] = '0;
        ry[6] = -sin_reg[1]; ry[7] = '0;          ry[8] = cos_reg[1];
        if (derivative)
        begin
            rx[0] = '0; rx[1] = '0;          rx[2] = '0;
            rx[3] = '0; rx[4] = -sin_reg[2]; rx[5] = -cos_reg[2];
            rx[6] = '0; rx[7] = cos_reg[2];  rx[8] = -sin_reg[2];
        end
        else
        begin
            rx[0] = ONE; rx[1] = '0;         rx[2] = '0;
            rx[3] = '0;  rx[4] = cos_reg[2]; rx[5] = -sin_reg[2];
            rx[6] = '0;  rx[7] = sin_reg[2]; rx[8] = cos_reg[2];
        end
    end

    // One multiply-accumulate step of the matrix product
    always_comb
    begin
        a_idx = 4'(row_reg) * 4'd3 + 4'(k_reg);
        b_idx = 4'(k_reg) * 4'd3 + 4'(col_reg);
        o_idx = 4'(row_reg) * 4'd3 + 4'(col_reg);
        a_val = pass_reg ? t_reg[a_idx] : rz[a_idx];
        b_val = pass_reg ? rx[b_idx] : ry[b_idx];
        prod  = a_val * b_val;
        sum   = ((k_reg == 2'd0) ? '0 : acc_reg) + ACC_W'(prod);
        rounded = (sum + HALF) >>> COEF_FRAC_BITS;
        if (rounded > ACC_W'(LIM_HI))
        begin
            res = LIM_HI;
        end
        else if (rounded < ACC_W'(LIM_LO))
        begin
            res = LIM_LO;
        end
        else
        begin
            res = rounded[COEF_W-1:0];
        end
    end

    // Sequence: three angles, then Rz*Ry, then that times Rx
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            trig_reg  <= TRIG_YAW;
            pass_reg  <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
            acc_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sin_reg[i] <= '0;
                cos_reg[i] <= '0;
            end
            for (int i = 0; i < 9; i++)
            begin
                t_reg[i]   <= '0;
                mat_reg[i] <= (i == 0 || i == 4 || i == 8) ? ONE : '0;
            end
        end
        else if (start)
        begin
            state_reg <= ST_TRIG;
            trig_reg  <= TRIG_YAW;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_TRIG:
                begin
                    if (trig_done)
                    begin
                        sin_reg[trig_reg] <= trig_sin;
                        cos_reg[trig_reg] <= trig_cos;
                        if (trig_reg == TRIG_ROLL)
                        begin
                            state_reg <= ST_MUL;
                            pass_reg  <= 1'b0;
                            row_reg   <= '0;
                            col_reg   <= '0;
                            k_reg     <= '0;
                        end
                        else
                        begin
                            trig_reg <= trig_reg + 2'd1;
                        end
                    end
                end
                ST_MUL:
                begin
                    acc_reg <= sum;
                    if (k_reg == IDX_LAST)
                    begin
                        k_reg <= '0;
                        if (pass_reg)
                        begin
                            mat_reg[o_idx] <= res;
                        end
                        else
                        begin
                            t_reg[o_idx] <= res;
                        end
                        if (col_reg == IDX_LAST)
                        begin
                            col_reg <= '0;
                            if (row_reg == IDX_LAST)
                            begin
                                row_reg <= '0;
                                if (pass_reg)
                                begin
                                    state_reg <= ST_IDLE;
                                end
                                pass_reg <= 1'b1;
                            end
                            else
                            begin
                                row_reg <= row_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            col_reg <= col_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            matrix[i] = mat_reg[i];
        end
    end

endmodule

`default_nettype wire

/* sv/erp_point_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none

module erp_point_pipe #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           hold,
    input  logic [8:0][COEF_FRAC_BITS+1:0] matrix,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  erp_pkg::point_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output erp_pkg::point_out_t            out_data
);

    localparam int CW     = erp_pkg::COORD_WIDTH;
    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int PROD_W = COEF_W + CW;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] OMAX = SUM_W'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] OMIN = ~OMAX;

    logic                    v1_reg, v2_reg, v3_reg;
    erp_pkg::point_in_t      p1_reg;
    logic signed [PROD_W-1:0] prod_reg [9];
    logic                    last2_reg;
    erp_pkg::point_out_t     out_reg;

    logic                    rdy1, rdy2, rdy3, accept;
    logic signed [CW-1:0]    coord [3];
    logic signed [PROD_W-1:0] prod_next [9];
    logic signed [SUM_W-1:0] sum [3];
    logic signed [SUM_W-1:0] shifted [3];
    logic signed [CW-1:0]    sat [3];

    // Each stage advances when the one after it is empty or moving
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1 && !hold;
    assign accept   = in_valid && in_ready;

    // Coefficient times coordinate, nine lanes
    always_comb
    begin
        coord[0] = p1_reg.x_coord;
        coord[1] = p1_reg.y_coord;
        coord[2] = p1_reg.z_coord;
        for (int i = 0; i < 9; i++)
        begin
            prod_next[i] = PROD_W'($signed(matrix[i])) * PROD_W'(coord[i % 3]);
        end
    end

    // Row sums, round half up, saturate
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum[r] = SUM_W'(prod_reg[3*r]) + SUM_W'(prod_reg[3*r+1])
                   + SUM_W'(prod_reg[3*r+2]) + HALF;
            shifted[r] = sum[r] >>> COEF_FRAC_BITS;
            if (shifted[r] > OMAX)
            begin
                sat[r] = OMAX[CW-1:0];
            end
            else if (shifted[r] < OMIN)
            begin
                sat[r] = OMIN[CW-1:0];
            end
            else
            begin
                sat[r] = shifted[r][CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= accept;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            p1_reg <= in_data;
        end
        if (rdy2)
        begin
            for (int i = 0; i < 9; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            last2_reg <= p1_reg.last_point;
        end
        if (rdy3)
        begin
            out_reg.x_rotated    <= sat[0];
            out_reg.y_rotated    <= sat[1];
            out_reg.z_rotated    <= sat[2];
            out_reg.last_rotated <= last2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    typedef longint coef_set_t [9];

    localparam int CYCLE_LIMIT = 400000;
    localparam longint COEF_ONE = 64'sd1 << 16;
    localparam longint COEF_LIM = 64'sd1 << 17;

    // Arctangent of 2^-i in units of 2^-32 turn
    localparam longint ATAN_STEP [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [erp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [erp_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    erp_pkg::point_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    erp_pkg::point_out_t out_data;

    erp_pkg::point_in_t pending_points [$];
    erp_pkg::point_out_t rotated_points [$];
    coef_set_t coef;
    logic [15:0] yaw_q, pitch_q, roll_q;
    logic deriv_q;
    logic in_took = 1'b0;
    logic no_idle = 1'b0;
    int mismatches = 0;
    int cycles = 0;

    euler_rotation_of_points dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sine and cosine of a binary angle, rounded to Q1.16
    function automatic void sin_cos_of(input logic [15:0] ang, output longint s,
                                       output longint c);
        longint x, y, z, dx, dy, cv, sv;
        x = 652032874;
        y = 0;
        z = longint'(ang[13:0]) << 16;
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN_STEP[i];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_STEP[i];
            end
        end
        cv = (x + (64'sd1 << 13)) >>> 14;
        sv = (y + (64'sd1 << 13)) >>> 14;
        case (ang[15:14])
            2'd0:    begin s = sv;  c = cv;  end
            2'd1:    begin s = cv;  c = -sv; end
            2'd2:    begin s = -sv; c = -cv; end
            default: begin s = -cv; c = sv;  end
        endcase
    endfunction

    // 3x3 product, rounded to Q1.16 and saturated to 18 bits
    function automatic coef_set_t coef_product(input coef_set_t a, input coef_set_t b);
        coef_set_t o;
        longint acc;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += a[r*3+k] * b[k*3+c];
                acc = (acc + (64'sd1 << 15)) >>> 16;
                o[r*3+c] = acc < -COEF_LIM ? -COEF_LIM : (acc > COEF_LIM - 1 ? COEF_LIM - 1 : acc);
            end
        return o;
    endfunction

    function automatic void rebuild_coef();
        longint sy, cy, sp, cp, sr, cr;
        coef_set_t rz, ry, rx;
        sin_cos_of(yaw_q, sy, cy);
        sin_cos_of(pitch_q, sp, cp);
        sin_cos_of(roll_q, sr, cr);
        rz = '{cy, -sy, 0, sy, cy, 0, 0, 0, COEF_ONE};
        ry = '{cp, 0, sp, 0, COEF_ONE, 0, -sp, 0, cp};
        if (deriv_q)
            rx = '{0, 0, 0, 0, -sr, -cr, 0, cr, -sr};
        else
            rx = '{COEF_ONE, 0, 0, 0, cr, -sr, 0, sr, cr};
        coef = coef_product(coef_product(rz, ry), rx);
    endfunction

    // One output coordinate: coefficient row dot point, split to avoid overflow
    function automatic logic [31:0] row_dot_point(input int r, input erp_pkg::point_in_t p);
        longint v [3];
        longint hi, lo, q, sum;
        v = '{longint'(p.x_coord), longint'(p.y_coord), longint'(p.z_coord)};
        hi = 0;
        lo = 0;
        for (int k = 0; k < 3; k++)
        begin
            hi += coef[r*3+k] * (v[k] >>> 24);
            lo += coef[r*3+k] * (v[k] & 64'hFF_FFFF);
        end
        if (hi >= (64'sd1 << 54))
            return 32'h7FFF_FFFF;
        if (hi <= -(64'sd1 << 54))
            return 32'h8000_0000;
        q = (lo + (64'sd1 << 15)) >>> 16;
        sum = hi * 256 + q;
        if (sum > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (sum < -64'sd2147483648)
            return 32'h8000_0000;
        return sum[31:0];
    endfunction

    function automatic erp_pkg::point_out_t rotate_point(input erp_pkg::point_in_t p);
        erp_pkg::point_out_t o;
        o.x_rotated = row_dot_point(0, p);
        o.y_rotated = row_dot_point(1, p);
        o.z_rotated = row_dot_point(2, p);
        o.last_rotated = p.last_point;
        return o;
    endfunction

    // Register write, then hold until the rebuild releases the input
    task automatic write_reg(input erp_pkg::cfg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            erp_pkg::CFG_YAW:   yaw_q = val;
            erp_pkg::CFG_PITCH: pitch_q = val;
            erp_pkg::CFG_ROLL:  roll_q = val;
            erp_pkg::CFG_MODE:  deriv_q = val[0];
        endcase
        rebuild_coef();
        repeat (3) @(negedge clk);
        while (!in_ready)
            @(negedge clk);
    endtask

    task automatic drain();
        while (pending_points.size() != 0 || in_valid || rotated_points.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
            2:       return $urandom_range(0, 32'h3FF_FFFF) - 32'h200_0000;
            default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
        endcase
    endfunction

    task automatic push_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic last);
        erp_pkg::point_in_t p;
        p.x_coord = x;
        p.y_coord = y;
        p.z_coord = z;
        p.last_point = last;
        pending_points.push_back(p);
    endtask

    task automatic push_edge_points();
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
        push_point(32'h0, 32'h0, 32'h0, 1'b0);
        push_point(32'h1_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    endtask

    // Driver: advance to the next point once the current beat is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                if (pending_points.size() != 0 && (no_idle || $urandom_range(0, 99) >= 14))
                begin
                    in_data <= pending_points.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= no_idle || $urandom_range(0, 99) >= 14;
        end
    end

    // Monitor: predict on input beats, compare on output beats
    always @(posedge clk)
    begin
        erp_pkg::point_out_t want;
        cycles <= cycles + 1;
        in_took = in_valid && in_ready;
        if (in_took)
            rotated_points.push_back(rotate_point(in_data));
        if (out_valid && out_ready)
        begin
            if (rotated_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat %h", out_data);
            end
            else
            begin
                want = rotated_points.pop_front();
                if (out_data.x_rotated !== want.x_rotated
                    || out_data.y_rotated !== want.y_rotated
                    || out_data.z_rotated !== want.z_rotated
                    || out_data.last_rotated !== want.last_rotated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                                 want.x_rotated, want.y_rotated, want.z_rotated,
                                 want.last_rotated, out_data.x_rotated,
                                 out_data.y_rotated, out_data.z_rotated,
                                 out_data.last_rotated);
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] angles [6];
        yaw_q = '0;
        pitch_q = '0;
        roll_q = '0;
        deriv_q = 1'b0;
        coef = '{COEF_ONE, 0, 0, 0, COEF_ONE, 0, 0, 0, COEF_ONE};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Identity matrix before any write
        push_edge_points();
        drain();

        // Extreme angles, both modes, quadrant boundaries
        angles = '{16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h3FFF, 16'h0000};
        write_reg(erp_pkg::CFG_YAW, angles[0]);
        write_reg(erp_pkg::CFG_PITCH, angles[1]);
        write_reg(erp_pkg::CFG_ROLL, angles[2]);
        push_edge_points();
        drain();
        write_reg(erp_pkg::CFG_MODE, 16'hFFFF);
        push_edge_points();
        drain();
        write_reg(erp_pkg::CFG_YAW, angles[3]);
        write_reg(erp_pkg::CFG_PITCH, angles[4]);
        write_reg(erp_pkg::CFG_ROLL, angles[5]);
        write_reg(erp_pkg::CFG_MODE, 16'hFFFE);
        push_edge_points();
        drain();

        // Random settings, each followed by a burst of points
        for (int ph = 0; ph < 12; ph++)
        begin
            no_idle = (ph == 5);
            for (int r = 0; r < 4; r++)
                if ($urandom_range(0, 3) != 0)
                    write_reg(erp_pkg::cfg_index_t'(r), 16'($urandom));
            for (int i = 0; i < 40; i++)
                push_point(rand_coord(), rand_coord(), rand_coord(),
                           1'($urandom_range(0, 1)));
            drain();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
